FILE: rtl/core/slcfr_pkg.sv
// Shared types, constants, the CRC byte update and the status kind decode for the sync/length/CRC frame receiver.
// No dependencies; imported by the receiver top level, its checker and the testbench.
package slcfr_pkg;

   // Framing constants.
   localparam logic [7:0]  SYNC_BYTE     = 8'h7E;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [7:0]  LENGTH_OFFSET = 8'd8;
   localparam logic [7:0]  STATUS_ADDR   = 8'hF0;
   localparam logic [7:0]  POLL_DEST     = 8'h02;
   localparam logic [7:0]  POLL_LENGTH   = 8'h04;
   localparam logic [7:0]  FUNC_FIVE     = 8'h05;

   // Length bytes of the known status frames.
   localparam logic [7:0] LEN_1C = 8'h1C;
   localparam logic [7:0] LEN_25 = 8'h25;
   localparam logic [7:0] LEN_2D = 8'h2D;
   localparam logic [7:0] LEN_3C = 8'h3C;
   localparam logic [7:0] LEN_40 = 8'h40;

   // Fixed frame positions.
   localparam int unsigned POS_DEST     = 2;
   localparam int unsigned POS_SRC      = 3;
   localparam int unsigned POS_LENGTH   = 5;
   localparam int unsigned POS_FUNCTION = 8;

   // Frame kind codes.
   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_UNKNOWN   = 3'd1;
   localparam logic [2:0] KIND_LEN1C     = 3'd2;
   localparam logic [2:0] KIND_LEN25_F5  = 3'd3;
   localparam logic [2:0] KIND_LEN25     = 3'd4;
   localparam logic [2:0] KIND_LEN2D     = 3'd5;
   localparam logic [2:0] KIND_LEN3C     = 3'd6;
   localparam logic [2:0] KIND_LEN40     = 3'd7;

   // One result transfer.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic [6:0] byte_index;
      logic       end_of_frame;
      logic       crc_good;
      logic [6:0] total_length;
      logic [2:0] frame_kind;
      logic       poll_seen;
      logic       overlength;
   } result_type;

   // CRC-16/Modbus update by one byte, reflected, eight shift steps.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Status frame kind from the stored header bytes.
   function automatic logic [2:0] decode_kind(input logic [7:0] dest, input logic [7:0] src,
                                              input logic [7:0] len, input logic [7:0] func);
      logic [2:0] kind;
      kind = KIND_UNKNOWN;
      case (len)
         LEN_1C:  kind = KIND_LEN1C;
         LEN_25:  kind = (func == FUNC_FIVE) ? KIND_LEN25_F5 : KIND_LEN25;
         LEN_2D:  kind = KIND_LEN2D;
         LEN_3C:  kind = KIND_LEN3C;
         LEN_40:  kind = KIND_LEN40;
         default: kind = KIND_UNKNOWN;
      endcase
      if (dest != STATUS_ADDR || src != STATUS_ADDR) begin
         kind = KIND_NONE;
      end
      return kind;
   endfunction

endpackage

FILE: rtl/core/sync_length_crc_frame_receiver.sv
// Results: each accepted byte past the two sync bytes is registered into the main or the skid output entry.
// Throughput: one byte per cycle while req_stall is low; the byte-wide CRC update and
// header decode sit between the frame state registers and a two-entry output register
// (main plus skid). req_stall rises only when the skid entry is occupied.
// Reset (synchronous): back to hunting for the first sync byte, CRC 0xFFFF, length 8,
// header bytes zero, output empty.
module sync_length_crc_frame_receiver #(
   parameter int unsigned MAX_FRAME_BYTES = 72
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic [6:0] rsp_byte_index,
   output logic       rsp_end_of_frame,
   output logic       rsp_crc_good,
   output logic [6:0] rsp_total_length,
   output logic [2:0] rsp_frame_kind,
   output logic       rsp_poll_seen,
   output logic       rsp_overlength
);
   import slcfr_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES);
   localparam int unsigned EXP_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [8:0]  MAX_LEN = 9'(MAX_FRAME_BYTES);
   localparam logic [EXP_W-1:0] MIN_LEN = EXP_W'(LENGTH_OFFSET);

   // Frame state.
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [EXP_W-1:0] exp_ff, exp_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       dest_ff, dest_in;
   logic [7:0]       src_ff, src_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       func_ff, func_in;
   logic [15:0]      rcv_ff, rcv_in;

   // Output register and skid entry.
   result_type rsp_data_ff, rsp_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic       accept;
   logic       push;
   logic       take;
   result_type result;
   logic [8:0] p9;
   logic [8:0] e9;
   logic [8:0] new_len;
   logic [EXP_W-1:0] exp_eff;
   logic       last;
   logic       good;
   logic       over;
   logic       hunting;

   assign accept  = req_valid && !req_stall;
   assign take    = rsp_valid_ff && !rsp_stall;
   assign hunting = (pos_ff < POS_W'(2));
   assign push    = accept && !hunting;

   // Per-byte frame logic.
   always_comb begin
      pos_in  = pos_ff;
      exp_in  = exp_ff;
      crc_in  = crc_ff;
      dest_in = dest_ff;
      src_in  = src_ff;
      len_in  = len_ff;
      func_in = func_ff;
      rcv_in  = rcv_ff;
      result  = '0;
      p9      = 9'(pos_ff);
      new_len = {1'b0, req_rx_byte} + 9'(LENGTH_OFFSET);
      over    = 1'b0;
      exp_eff = exp_ff;
      last    = 1'b0;
      good    = 1'b0;

      if (pos_ff == POS_W'(POS_DEST))     dest_in = req_rx_byte;
      if (pos_ff == POS_W'(POS_SRC))      src_in  = req_rx_byte;
      if (pos_ff == POS_W'(POS_FUNCTION)) func_in = req_rx_byte;
      if (pos_ff == POS_W'(POS_LENGTH)) begin
         len_in = req_rx_byte;
         if (new_len > MAX_LEN) begin
            over = 1'b1;
         end else begin
            exp_eff = EXP_W'(new_len);
         end
      end
      e9 = 9'(exp_eff);

      // Running CRC, then the received CRC low and high bytes.
      if (p9 + 9'd3 < e9) begin
         crc_in = crc_feed(crc_ff, req_rx_byte);
      end else if (p9 + 9'd3 == e9) begin
         rcv_in = {rcv_ff[15:8], req_rx_byte};
      end else if (p9 + 9'd2 == e9) begin
         rcv_in = {req_rx_byte, rcv_ff[7:0]};
      end
      last = (p9 + 9'd1 >= e9);
      good = last && (rcv_in == crc_ff);

      result.frame_byte = req_rx_byte;
      result.byte_index = 7'(pos_ff);
      if (over) begin
         result.end_of_frame = 1'b1;
         result.overlength   = 1'b1;
      end else begin
         result.end_of_frame = last;
         result.crc_good     = good;
         result.total_length = 7'(exp_eff);
         result.frame_kind   = good ? decode_kind(dest_in, src_in, len_in, func_in) : KIND_NONE;
         result.poll_seen    = good && dest_in == POLL_DEST && src_in == STATUS_ADDR
                               && len_in == POLL_LENGTH;
      end

      // Sync hunt or frame advance.
      if (hunting) begin
         crc_in = crc_ff;
         rcv_in = rcv_ff;
         if (req_rx_byte == SYNC_BYTE) begin
            crc_in = crc_feed(crc_ff, req_rx_byte);
            pos_in = pos_ff + POS_W'(1);
         end
      end else if (over || last) begin
         pos_in = '0;
         exp_in = MIN_LEN;
         crc_in = CRC_INIT;
      end else begin
         exp_in = exp_eff;
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         exp_ff  <= MIN_LEN;
         crc_ff  <= CRC_INIT;
         dest_ff <= '0;
         src_ff  <= '0;
         len_ff  <= '0;
         func_ff <= '0;
         rcv_ff  <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         exp_ff  <= exp_in;
         crc_ff  <= crc_in;
         dest_ff <= dest_in;
         src_ff  <= src_in;
         len_ff  <= len_in;
         func_ff <= func_in;
         rcv_ff  <= rcv_in;
      end
   end

   // Output register with skid entry; the skid drains into the main entry first.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_in  = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Port outputs.
   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = rsp_data_ff.frame_byte;
   assign rsp_byte_index   = rsp_data_ff.byte_index;
   assign rsp_end_of_frame = rsp_data_ff.end_of_frame;
   assign rsp_crc_good     = rsp_data_ff.crc_good;
   assign rsp_total_length = rsp_data_ff.total_length;
   assign rsp_frame_kind   = rsp_data_ff.frame_kind;
   assign rsp_poll_seen    = rsp_data_ff.poll_seen;
   assign rsp_overlength   = rsp_data_ff.overlength;

endmodule

FILE: rtl/core/slcfr_checker.sv
// Port-level checker for the sync/length/CRC frame receiver, bound to the top level.
// Depends on slcfr_pkg for the frame kind codes.
module slcfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_frame_byte,
   input logic [6:0] rsp_byte_index,
   input logic       rsp_end_of_frame,
   input logic       rsp_crc_good,
   input logic [6:0] rsp_total_length,
   input logic [2:0] rsp_frame_kind,
   input logic       rsp_poll_seen,
   input logic       rsp_overlength
);
   import slcfr_pkg::*;

   // A stalled result transfer holds its byte and position.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
                                 && $stable(rsp_byte_index))
      else $error("stalled result changed");

   // Frame verdicts appear only on the final byte.
   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_frame |-> !rsp_crc_good && rsp_frame_kind == KIND_NONE
                                         && !rsp_poll_seen && !rsp_overlength)
      else $error("verdict on a non-final byte");

   // An overlength abort ends the frame with no length and no verdict.
   a_overlength: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overlength |-> rsp_end_of_frame && rsp_total_length == 7'd0
                                      && !rsp_crc_good)
      else $error("malformed overlength abort");

   // Poll detection and status kinds require a good CRC.
   a_needs_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_poll_seen || rsp_frame_kind != KIND_NONE) |-> rsp_crc_good)
      else $error("frame decode without good CRC");

endmodule

bind sync_length_crc_frame_receiver slcfr_checker u_slcfr_checker (.*);

FILE: tb/sync_length_crc_frame_receiver_tb.sv
// Self-checking testbench for the sync/length/CRC frame receiver.
// Depends on slcfr_pkg and sync_length_crc_frame_receiver; a built-in frame tracker
// predicts every result, and random idling and stalls are applied on both channels.
module sync_length_crc_frame_receiver_tb;
   import slcfr_pkg::*;

   localparam int unsigned MAX_FRAME      = 72;
   localparam int unsigned RANDOM_ITEMS   = 1500;
   localparam int unsigned HOLDOFF_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned CYCLE_LIMIT    = 600000;

   typedef enum logic [1:0] {ROW_DATA, ROW_CRC_LO, ROW_CRC_HI} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   data;
      bit           typed;
      result_type   want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_frame_byte;
   logic [6:0] rsp_byte_index;
   logic       rsp_end_of_frame;
   logic       rsp_crc_good;
   logic [6:0] rsp_total_length;
   logic [2:0] rsp_frame_kind;
   logic       rsp_poll_seen;
   logic       rsp_overlength;

   // Frame tracker state, mirrors the receiver's own registers.
   int unsigned trk_pos = 0;
   int unsigned trk_total = 8;
   logic [15:0] trk_crc = CRC_INIT;
   logic [7:0]  trk_dest = 8'h00;
   logic [7:0]  trk_src = 8'h00;
   logic [7:0]  trk_len_byte = 8'h00;
   logic [7:0]  trk_func = 8'h00;
   logic [15:0] trk_rx_crc = 16'h0000;

   result_type   pending_results[$];
   stim_row_type stim_rows[$];
   int unsigned  fail_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  result_items = 0;
   logic         holdoff_req = 1'b0;

   sync_length_crc_frame_receiver #(
      .MAX_FRAME_BYTES(MAX_FRAME)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_end_of_frame(rsp_end_of_frame),
      .rsp_crc_good(rsp_crc_good),
      .rsp_total_length(rsp_total_length),
      .rsp_frame_kind(rsp_frame_kind),
      .rsp_poll_seen(rsp_poll_seen),
      .rsp_overlength(rsp_overlength)
   );

   always #2 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // CRC-16/Modbus, one data bit at a time, LSB first.
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] c;
      bit          fb;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic void rehunt();
      trk_pos = 0;
      trk_total = 8;
      trk_crc = CRC_INIT;
   endfunction

   // Advances the tracker by one accepted byte; returns 1 when a result is due.
   function automatic bit frame_track(input logic [7:0] b, output result_type r);
      int unsigned p;
      p = trk_pos;
      r = '0;
      if (p < 2) begin
         if (b == SYNC_BYTE) begin
            trk_crc = crc16_step(trk_crc, b);
            trk_pos = p + 1;
         end
         return 1'b0;
      end
      r.frame_byte = b;
      r.byte_index = p[6:0];
      if (p == POS_DEST) trk_dest = b;
      if (p == POS_SRC) trk_src = b;
      if (p == POS_FUNCTION) trk_func = b;
      if (p == POS_LENGTH) begin
         trk_len_byte = b;
         if (int'(b) + int'(LENGTH_OFFSET) > MAX_FRAME) begin
            r.end_of_frame = 1'b1;
            r.overlength = 1'b1;
            rehunt();
            return 1'b1;
         end
         trk_total = int'(b) + int'(LENGTH_OFFSET);
      end

      // Bytes before the CRC pair feed the CRC; the pair itself is stored little-endian.
      if (p + 3 < trk_total) begin
         trk_crc = crc16_step(trk_crc, b);
      end else if (p + 3 == trk_total) begin
         trk_rx_crc[7:0] = b;
      end else if (p + 2 == trk_total) begin
         trk_rx_crc[15:8] = b;
      end

      r.total_length = trk_total[6:0];
      if (p + 1 >= trk_total) begin
         r.end_of_frame = 1'b1;
         r.frame_kind = KIND_NONE;
         if (trk_rx_crc == trk_crc) begin
            r.crc_good = 1'b1;
            if (trk_dest == STATUS_ADDR && trk_src == STATUS_ADDR) begin
               case (trk_len_byte)
                  LEN_1C:  r.frame_kind = KIND_LEN1C;
                  LEN_25:  r.frame_kind = (trk_func == FUNC_FIVE) ? KIND_LEN25_F5 : KIND_LEN25;
                  LEN_2D:  r.frame_kind = KIND_LEN2D;
                  LEN_3C:  r.frame_kind = KIND_LEN3C;
                  LEN_40:  r.frame_kind = KIND_LEN40;
                  default: r.frame_kind = KIND_UNKNOWN;
               endcase
            end
            r.poll_seen = (trk_dest == POLL_DEST && trk_src == STATUS_ADDR &&
                           trk_len_byte == POLL_LENGTH);
         end
         rehunt();
      end else begin
         trk_pos = p + 1;
      end
      return 1'b1;
   endfunction

   function automatic result_type mk_result(input logic [7:0] fb, input logic [6:0] idx,
                                            input bit eof, input bit good,
                                            input logic [6:0] tot, input logic [2:0] kind,
                                            input bit poll, input bit ovl);
      result_type r;
      r.frame_byte = fb;
      r.byte_index = idx;
      r.end_of_frame = eof;
      r.crc_good = good;
      r.total_length = tot;
      r.frame_kind = kind;
      r.poll_seen = poll;
      r.overlength = ovl;
      return r;
   endfunction

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic add_row(input row_kind_type kind, input logic [7:0] data, input bit typed,
                          input result_type want);
      stim_row_type row;
      row.kind = kind;
      row.data = data;
      row.typed = typed;
      row.want = want;
      stim_rows.push_back(row);
   endtask

   // Offers one byte after an optional idle gap and waits for the transfer.
   task automatic send_byte(input logic [7:0] b, input int unsigned gap, input bit typed,
                            input result_type want);
      result_type r;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (frame_track(b, r)) begin
         pending_results.push_back(typed ? want : r);
         result_items++;
      end
   endtask

   // One random frame: mostly well formed with random content, sometimes noise or broken.
   task automatic send_frame(input bit calm);
      int unsigned lenb;
      int unsigned total;
      int unsigned roll;
      int unsigned n;
      logic [7:0]  dest;
      logic [7:0]  src;
      logic [7:0]  fn;
      logic [7:0]  b;
      logic [15:0] flip;

      // Line noise while hunting for sync.
      if ($urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == SYNC_BYTE) b = ~b;
            send_byte(b, pick_gap(calm), 1'b0, '0);
         end
      end

      // Sync followed by pure garbage.
      if ($urandom_range(0, 99) < 5) begin
         send_byte(SYNC_BYTE, pick_gap(calm), 1'b0, '0);
         send_byte(SYNC_BYTE, pick_gap(calm), 1'b0, '0);
         n = $urandom_range(1, 20);
         repeat (n) send_byte(8'($urandom_range(0, 255)), pick_gap(calm), 1'b0, '0);
         return;
      end

      dest = 8'($urandom_range(0, 255));
      src = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         lenb = $urandom_range(0, 12);
      end else if (roll < 55) begin
         lenb = 32'(POLL_LENGTH);
         if ($urandom_range(0, 99) < 85) begin
            dest = POLL_DEST;
            src = STATUS_ADDR;
         end
      end else if (roll < 80) begin
         case ($urandom_range(0, 4))
            0:       lenb = 32'(LEN_1C);
            1:       lenb = 32'(LEN_25);
            2:       lenb = 32'(LEN_2D);
            3:       lenb = 32'(LEN_3C);
            default: lenb = 32'(LEN_40);
         endcase
      end else if (roll < 88) begin
         lenb = $urandom_range(MAX_FRAME - 7, 255);
      end else if (roll < 93) begin
         lenb = $urandom_range(MAX_FRAME - 8, MAX_FRAME - 7);
      end else begin
         lenb = $urandom_range(0, MAX_FRAME - 8);
      end
      if (roll >= 40 && roll < 93 && lenb != 32'(POLL_LENGTH) &&
          $urandom_range(0, 99) < 80) begin
         dest = STATUS_ADDR;
         src = STATUS_ADDR;
      end
      fn = ($urandom_range(0, 1) == 0) ? FUNC_FIVE : 8'($urandom_range(0, 255));
      flip = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
      total = lenb + 32'(LENGTH_OFFSET);

      send_byte(SYNC_BYTE, pick_gap(calm), 1'b0, '0);
      send_byte(SYNC_BYTE, pick_gap(calm), 1'b0, '0);
      for (int unsigned p = 2; p < total; p++) begin
         if (p == POS_DEST) b = dest;
         else if (p == POS_SRC) b = src;
         else if (p == POS_LENGTH) b = lenb[7:0];
         else if (p == total - 3) b = trk_crc[7:0] ^ flip[7:0];
         else if (p == total - 2) b = trk_crc[15:8] ^ flip[15:8];
         else if (p == POS_FUNCTION) b = fn;
         else b = 8'($urandom_range(0, 255));
         send_byte(b, pick_gap(calm), 1'b0, '0);
         if (p == POS_LENGTH && total > MAX_FRAME) break;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Result side: check each transfer, then plan the next stall.
   int unsigned hold_left = 0;
   int unsigned phase_left = 0;
   bit          rx_calm = 1'b0;
   bit          holdoff_done = 1'b0;

   always @(posedge clock) begin
      result_type  want;
      int unsigned roll;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: byte %0h at index %0d", rsp_frame_byte, rsp_byte_index);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("frame_byte", 16'(want.frame_byte), 16'(rsp_frame_byte));
            check_field("byte_index", 16'(want.byte_index), 16'(rsp_byte_index));
            check_field("end_of_frame", 16'(want.end_of_frame), 16'(rsp_end_of_frame));
            check_field("crc_good", 16'(want.crc_good), 16'(rsp_crc_good));
            check_field("total_length", 16'(want.total_length), 16'(rsp_total_length));
            check_field("frame_kind", 16'(want.frame_kind), 16'(rsp_frame_kind));
            check_field("poll_seen", 16'(want.poll_seen), 16'(rsp_poll_seen));
            check_field("overlength", 16'(want.overlength), 16'(rsp_overlength));
         end
      end

      // One long hold-off on request, so the receiver backs up into its input.
      if (holdoff_req && !holdoff_done) begin
         hold_left = HOLDOFF_CYCLES;
         holdoff_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            rx_calm = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(50, 400);
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (rx_calm || roll < 65) begin
            rsp_stall <= 1'b0;
         end else if (roll < 95) begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            hold_left = $urandom_range(8, 40);
         end
      end
   end

   // Stimulus: directed rows first, then random frames.
   initial begin
      result_type none;
      logic [7:0] b;
      int unsigned frame_no;
      bit          calm;
      none = '0;

      // Hunting: noise before the first sync and between the two sync bytes.
      add_row(ROW_DATA, 8'h00, 1'b0, none);
      add_row(ROW_DATA, 8'hFF, 1'b0, none);
      add_row(ROW_DATA, SYNC_BYTE, 1'b0, none);
      add_row(ROW_DATA, 8'h12, 1'b0, none);
      add_row(ROW_DATA, SYNC_BYTE, 1'b0, none);
      // Extremes, then a length byte of 0xFF that overruns the buffer.
      add_row(ROW_DATA, 8'hFF, 1'b1,
              mk_result(8'hFF, 7'd2, 1'b0, 1'b0, 7'd8, KIND_NONE, 1'b0, 1'b0));
      add_row(ROW_DATA, 8'h00, 1'b1,
              mk_result(8'h00, 7'd3, 1'b0, 1'b0, 7'd8, KIND_NONE, 1'b0, 1'b0));
      add_row(ROW_DATA, 8'hAA, 1'b0, none);
      add_row(ROW_DATA, 8'hFF, 1'b1,
              mk_result(8'hFF, 7'd5, 1'b1, 1'b0, 7'd0, KIND_NONE, 1'b0, 1'b1));
      // Poll frame with a good CRC.
      add_row(ROW_DATA, SYNC_BYTE, 1'b0, none);
      add_row(ROW_DATA, SYNC_BYTE, 1'b0, none);
      add_row(ROW_DATA, POLL_DEST, 1'b0, none);
      add_row(ROW_DATA, STATUS_ADDR, 1'b0, none);
      add_row(ROW_DATA, 8'h11, 1'b0, none);
      add_row(ROW_DATA, POLL_LENGTH, 1'b0, none);
      add_row(ROW_DATA, 8'hA5, 1'b0, none);
      add_row(ROW_DATA, 8'h5A, 1'b0, none);
      add_row(ROW_DATA, FUNC_FIVE, 1'b0, none);
      add_row(ROW_CRC_LO, 8'h00, 1'b0, none);
      add_row(ROW_CRC_HI, 8'h00, 1'b0, none);
      add_row(ROW_DATA, 8'h7F, 1'b1,
              mk_result(8'h7F, 7'd11, 1'b1, 1'b1, 7'd12, KIND_NONE, 1'b1, 1'b0));
      // Short frame: length byte 0 doubles as the low CRC byte.
      add_row(ROW_DATA, SYNC_BYTE, 1'b0, none);
      add_row(ROW_DATA, SYNC_BYTE, 1'b0, none);
      add_row(ROW_DATA, STATUS_ADDR, 1'b0, none);
      add_row(ROW_DATA, STATUS_ADDR, 1'b0, none);
      add_row(ROW_DATA, 8'hFF, 1'b0, none);
      add_row(ROW_DATA, 8'h00, 1'b0, none);
      add_row(ROW_CRC_HI, 8'h00, 1'b0, none);
      add_row(ROW_DATA, 8'h00, 1'b0, none);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         case (stim_rows[i].kind)
            ROW_CRC_LO: b = trk_crc[7:0];
            ROW_CRC_HI: b = trk_crc[15:8];
            default:    b = stim_rows[i].data;
         endcase
         send_byte(b, pick_gap(1'b0), stim_rows[i].typed, stim_rows[i].want);
      end

      // Random frames; frames four to six run back to back under the long hold-off.
      frame_no = 0;
      while (result_items < RANDOM_ITEMS) begin
         if (frame_no == 4) holdoff_req <= 1'b1;
         calm = (frame_no >= 4 && frame_no <= 6) || ($urandom_range(0, 4) == 0);
         send_frame(calm);
         frame_no++;
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
